// ----- rtl/asso_pkg.sv -----
// ----------------------------------------------------------------------------
// asso_pkg
// Shared types and constants for the addressed serial shift-out unit.
// ----------------------------------------------------------------------------
package asso_pkg;

    localparam int BUFFER_BITS_DEF = 16;
    localparam int ADDR_BITS       = 8;
    localparam int TAIL_WORDS      = 5;

    typedef enum logic [2:0] {
        S_IDLE,
        S_BUILD,
        S_PRE,
        S_ADDR,
        S_DATA,
        S_TAIL
    } t_state;

    typedef struct packed {
        logic       wr;
        logic [5:0] pos;
        logic       data;
        logic       enable;
    } t_store_wr;

endpackage

// ----- rtl/asso_bit_store.sv -----
// ----------------------------------------------------------------------------
// asso_bit_store
// Data and enable bit store: one write per cycle, one indexed read plus the
// enable bit of position zero.
// ----------------------------------------------------------------------------
module asso_bit_store #(
    parameter int BUFFER_BITS = asso_pkg::BUFFER_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  asso_pkg::t_store_wr i_wr,
    input  logic [4:0]          i_rd_idx,
    output logic                o_rd_data,
    output logic                o_rd_enable,
    output logic                o_enable0
);
    import asso_pkg::*;

    logic [BUFFER_BITS-1:0] r_data;
    logic [BUFFER_BITS-1:0] r_enable;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data   <= '0;
            r_enable <= '0;
        end else begin
            for (int i = 0; i < BUFFER_BITS; i++) begin
                if (i_wr.wr && i_wr.pos == 6'(i)) begin
                    r_data[i]   <= i_wr.data;
                    r_enable[i] <= i_wr.enable;
                end
            end
        end
    end

    always_comb begin
        o_rd_data   = 1'b0;
        o_rd_enable = 1'b0;
        for (int i = 0; i < BUFFER_BITS; i++) begin
            if (i_rd_idx == 5'(i)) begin
                o_rd_data   = r_data[i];
                o_rd_enable = r_enable[i];
            end
        end
    end

    assign o_enable0 = r_enable[0];

endmodule

// ----- rtl/addressed_serial_shift_out_unit.sv -----
// ----------------------------------------------------------------------------
// addressed_serial_shift_out_unit
// Bit store with build and send commands driving a bit-banged serial bus.
//
// Usage: the input channel (i_in_valid / o_in_stall) takes one command per
// transfer. A build command (cmd 0) writes one store bit per cycle, then
// offers its single result. A send command (cmd 1) produces pin-state words:
// one idle word, 16 address words, 2 * send_length data words (length capped
// at BUFFER_BITS) and 5 trailer words, at most 54 results. The single
// sequencer and output register set the rate of a send: one result per cycle
// while the output is not stalled, none in the step from data to trailer.
// o_in_stall is high after acceptance until the last result of the item has
// been loaded into the output register. The output channel (o_out_valid /
// i_out_stall) holds its payload while stalled, and the sequencer waits
// before loading its next result. Reset is synchronous and active low; it
// clears the store to all zero and empties the output register.
// ----------------------------------------------------------------------------
module addressed_serial_shift_out_unit #(
    parameter int BUFFER_BITS = asso_pkg::BUFFER_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_cmd,
    input  logic [15:0] i_data_word,
    input  logic [4:0]  i_bit_count,
    input  logic [3:0]  i_start_position,
    input  logic        i_enable_high,
    input  logic [7:0]  i_device_address,
    input  logic [4:0]  i_send_length,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_addr_line,
    output logic        o_clk_line,
    output logic        o_en_line,
    output logic        o_din_line,
    output logic [4:0]  o_next_position,
    output logic        o_overrun,
    output logic        o_last
);
    import asso_pkg::*;

    localparam logic [4:0] BUF_LEN = 5'(BUFFER_BITS);

    t_state      r_state, n_state;
    logic [4:0]  r_cnt, n_cnt;
    logic        r_half, n_half;
    logic        r_en, n_en;
    logic        r_ovr, n_ovr;
    logic [15:0] r_word;
    logic [4:0]  r_count;
    logic [3:0]  r_start;
    logic        r_en_hi;
    logic [7:0]  r_dev;
    logic [4:0]  r_len;

    logic        r_out_valid, n_out_valid;
    logic        r_addr, n_addr;
    logic        r_clk, n_clk;
    logic        r_enl, n_enl;
    logic        r_din, n_din;
    logic [4:0]  r_nextp, n_nextp;
    logic        r_ovr_out, n_ovr_out;
    logic        r_last, n_last;

    t_store_wr   s_wr;
    logic        s_rd_data;
    logic        s_rd_enable;
    logic        s_enable0;
    logic        can_emit;
    logic        accept;
    logic [5:0]  pos;
    logic [4:0]  sh;
    logic [5:0]  sum;

    asso_bit_store #(
        .BUFFER_BITS(BUFFER_BITS)
    ) u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (s_wr),
        .i_rd_idx   (r_cnt),
        .o_rd_data  (s_rd_data),
        .o_rd_enable(s_rd_enable),
        .o_enable0  (s_enable0)
    );

    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && (r_state == S_IDLE);
    assign can_emit   = !r_out_valid || !i_out_stall;
    assign pos        = {2'b00, r_start} + {1'b0, r_cnt};
    assign sh         = r_count - 5'd1 - r_cnt;
    assign sum        = {2'b00, r_start} + {1'b0, r_count};

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_half      = r_half;
        n_en        = r_en;
        n_ovr       = r_ovr;
        n_out_valid = r_out_valid && i_out_stall;
        n_addr      = r_addr;
        n_clk       = r_clk;
        n_enl       = r_enl;
        n_din       = r_din;
        n_nextp     = r_nextp;
        n_ovr_out   = r_ovr_out;
        n_last      = r_last;
        s_wr        = '0;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_cnt  = '0;
                    n_half = 1'b0;
                    n_ovr  = 1'b0;
                    n_en   = s_enable0;
                    n_state = i_cmd ? S_PRE : S_BUILD;
                end
            end
            S_BUILD: begin
                if (r_cnt == r_count) begin
                    if (can_emit) begin
                        n_out_valid = 1'b1;
                        n_addr      = 1'b0;
                        n_clk       = 1'b0;
                        n_enl       = 1'b0;
                        n_din       = 1'b0;
                        n_nextp     = sum[5] ? 5'd31 : sum[4:0];
                        n_ovr_out   = r_ovr;
                        n_last      = 1'b1;
                        n_state     = S_IDLE;
                    end
                end else begin
                    s_wr.pos    = pos;
                    s_wr.data   = sh[4] ? 1'b0 : r_word[sh[3:0]];
                    s_wr.enable = r_en_hi;
                    if (pos < 6'(BUFFER_BITS)) begin
                        s_wr.wr = 1'b1;
                    end else begin
                        n_ovr = 1'b1;
                    end
                    n_cnt = r_cnt + 5'd1;
                end
            end
            S_PRE: begin
                if (can_emit) begin
                    n_out_valid = 1'b1;
                    n_addr      = 1'b1;
                    n_clk       = 1'b0;
                    n_enl       = r_en;
                    n_din       = 1'b0;
                    n_nextp     = '0;
                    n_ovr_out   = 1'b0;
                    n_last      = 1'b0;
                    n_state     = S_ADDR;
                end
            end
            S_ADDR: begin
                if (can_emit) begin
                    n_out_valid = 1'b1;
                    n_addr      = 1'b1;
                    n_clk       = r_half;
                    n_enl       = r_en;
                    n_din       = r_dev[r_cnt[2:0]];
                    n_half      = !r_half;
                    if (r_half) begin
                        if (r_cnt == 5'(ADDR_BITS - 1)) begin
                            n_cnt   = '0;
                            n_state = S_DATA;
                        end else begin
                            n_cnt = r_cnt + 5'd1;
                        end
                    end
                end
            end
            S_DATA: begin
                if (r_cnt == r_len) begin
                    n_cnt   = '0;
                    n_state = S_TAIL;
                end else if (can_emit) begin
                    n_out_valid = 1'b1;
                    n_addr      = 1'b0;
                    n_clk       = r_half;
                    n_enl       = s_rd_enable;
                    n_din       = s_rd_data;
                    n_en        = s_rd_enable;
                    n_half      = !r_half;
                    if (r_half) begin
                        n_cnt = r_cnt + 5'd1;
                    end
                end
            end
            S_TAIL: begin
                if (can_emit) begin
                    n_out_valid = 1'b1;
                    n_addr      = (r_cnt >= 5'd3);
                    n_clk       = 1'b0;
                    n_enl       = (r_cnt >= 5'd2) ? !r_en : r_en;
                    n_din       = 1'b0;
                    n_last      = (r_cnt == 5'(TAIL_WORDS - 1));
                    if (r_cnt == 5'(TAIL_WORDS - 1)) begin
                        n_state = S_IDLE;
                    end else begin
                        n_cnt = r_cnt + 5'd1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt     <= n_cnt;
        r_half    <= n_half;
        r_en      <= n_en;
        r_ovr     <= n_ovr;
        r_addr    <= n_addr;
        r_clk     <= n_clk;
        r_enl     <= n_enl;
        r_din     <= n_din;
        r_nextp   <= n_nextp;
        r_ovr_out <= n_ovr_out;
        r_last    <= n_last;
        if (accept) begin
            r_word  <= i_data_word;
            r_count <= i_bit_count;
            r_start <= i_start_position;
            r_en_hi <= i_enable_high;
            r_dev   <= i_device_address;
            r_len   <= (i_send_length > BUF_LEN) ? BUF_LEN : i_send_length;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_addr_line     = r_addr;
    assign o_clk_line      = r_clk;
    assign o_en_line       = r_enl;
    assign o_din_line      = r_din;
    assign o_next_position = r_nextp;
    assign o_overrun       = r_ovr_out;
    assign o_last          = r_last;

endmodule
